FILE: hdl/plst_pkg.sv
// plst_pkg: shared types and codes for the positional list store
// action and status codes, cell command struct
// no dependencies
package plst_pkg;

	// default depth of the cell chain
	localparam int CAPACITY_DEF = 32;

	// width of index and tail fields in the cell command, covers depth up to 128
	localparam int IDXW = 7;

	// action codes
	localparam logic [2:0] ACT_INS_FRONT = 3'd0;
	localparam logic [2:0] ACT_INS_BACK  = 3'd1;
	localparam logic [2:0] ACT_INS_POS   = 3'd2;
	localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
	localparam logic [2:0] ACT_DEL_BACK  = 3'd4;
	localparam logic [2:0] ACT_DEL_POS   = 3'd5;
	localparam logic [2:0] ACT_READ_ALL  = 3'd6;

	// status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_DEL,
		OP_ROT
	} cell_op_t;

	// command broadcast along the chain
	typedef struct packed {
		cell_op_t          op;
		logic [IDXW-1:0]   idx;
		logic [IDXW-1:0]   tail;
	} cell_cmd_t;

endpackage

FILE: hdl/plst_cell.sv
// plst_cell: one storage cell of the list chain
// shifts toward back on insert, toward front on delete, rotates on read-out
// depends on plst_pkg
module plst_cell #(
	parameter int INDEX = 0
) (
	input  logic                 clk,
	input  plst_pkg::cell_cmd_t  cmd,
	input  logic signed [31:0]   ins_value,
	input  logic signed [31:0]   left_data,
	input  logic signed [31:0]   right_data,
	input  logic signed [31:0]   front_data,
	output logic signed [31:0]   data
);

	localparam logic [plst_pkg::IDXW-1:0] MY_IDX = plst_pkg::IDXW'(INDEX);

	logic signed [31:0] data_q;
	logic signed [31:0] data_d;

	// next value by broadcast command and own place in the chain
	always_comb begin
		data_d = data_q;
		case (cmd.op)
			plst_pkg::OP_INS: begin
				if (MY_IDX == cmd.idx)
					data_d = ins_value;
				else if (MY_IDX > cmd.idx)
					data_d = left_data;
			end
			plst_pkg::OP_DEL: begin
				if (MY_IDX >= cmd.idx)
					data_d = right_data;
			end
			plst_pkg::OP_ROT: begin
				if (MY_IDX == cmd.tail)
					data_d = front_data;
				else
					data_d = right_data;
			end
			default: data_d = data_q;
		endcase
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

FILE: hdl/positional_list_store.sv
// positional_list_store: ordered list of signed 32-bit values in a chain of cells
// one registered result in the cycle after an accepted beat for every action but read-out
// throughput: one beat per cycle for inserts and deletes while not busy; read-out holds
// busy while count elements are rotated out of the front cell, one element per cycle
// reset: arst_n clears the count and control; cell contents are not cleared
// results are strobed on valid for one cycle and cannot be stalled
module positional_list_store #(
	parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic signed [31:0] value,
	input  logic [6:0]         position,
	output logic               valid,
	output logic signed [31:0] element,
	output logic [1:0]         status,
	output logic [5:0]         count,
	output logic               last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = plst_pkg::IDXW;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic [CW-1:0] held_q;
	logic [CW-1:0] rd_cnt_q;
	logic valid_q;
	logic signed [31:0] element_q;
	logic [1:0] status_q;
	logic last_q;

	plst_pkg::cell_cmd_t cmd;
	logic signed [31:0] cell_data [CAPACITY];

	logic accept;
	logic full;
	logic [7:0] held8;
	logic [7:0] pos8;
	logic [IW-1:0] held_i;
	logic [IW-1:0] pos_m1;
	logic [1:0] st_d;
	logic go_read;

	assign accept = start && (state_q == S_IDLE);
	assign full   = (held_q == CW'(CAPACITY));
	assign held8  = 8'(held_q);
	assign pos8   = {1'b0, position};
	assign held_i = IW'(held_q);
	assign pos_m1 = IW'(position - 7'd1);

	// decode the beat into a chain command and a status
	always_comb begin
		cmd.op   = plst_pkg::OP_HOLD;
		cmd.idx  = '0;
		cmd.tail = held_i - IW'(1);
		st_d     = plst_pkg::ST_DONE;
		go_read  = 1'b0;
		if (state_q == S_READ) begin
			cmd.op = plst_pkg::OP_ROT;
		end else if (accept) begin
			unique case (action)
				plst_pkg::ACT_INS_FRONT: begin
					if (full) st_d = plst_pkg::ST_FULL;
					else cmd.op = plst_pkg::OP_INS;
				end
				plst_pkg::ACT_INS_BACK: begin
					cmd.idx = held_i;
					if (full) st_d = plst_pkg::ST_FULL;
					else cmd.op = plst_pkg::OP_INS;
				end
				plst_pkg::ACT_INS_POS: begin
					cmd.idx = pos_m1;
					if (pos8 == 8'd0 || pos8 > held8 + 8'd1) st_d = plst_pkg::ST_BADPOS;
					else if (full) st_d = plst_pkg::ST_FULL;
					else cmd.op = plst_pkg::OP_INS;
				end
				plst_pkg::ACT_DEL_FRONT: begin
					if (held_q == '0) st_d = plst_pkg::ST_EMPTY;
					else cmd.op = plst_pkg::OP_DEL;
				end
				plst_pkg::ACT_DEL_BACK: begin
					cmd.idx = held_i - IW'(1);
					if (held_q == '0) st_d = plst_pkg::ST_EMPTY;
					else cmd.op = plst_pkg::OP_DEL;
				end
				plst_pkg::ACT_DEL_POS: begin
					cmd.idx = pos_m1;
					if (pos8 == 8'd0 || pos8 > held8) st_d = plst_pkg::ST_BADPOS;
					else cmd.op = plst_pkg::OP_DEL;
				end
				plst_pkg::ACT_READ_ALL: begin
					if (held_q == '0) st_d = plst_pkg::ST_EMPTY;
					else go_read = 1'b1;
				end
				default: st_d = plst_pkg::ST_DONE;
			endcase
		end
	end

	// chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = cell_data[i];
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		plst_cell #(.INDEX(i)) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.ins_value  (value),
			.left_data  (left_d),
			.right_data (right_d),
			.front_data (cell_data[0]),
			.data       (cell_data[i])
		);
	end

	// control state, count and registered result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			held_q    <= '0;
			rd_cnt_q  <= '0;
			valid_q   <= 1'b0;
			status_q  <= plst_pkg::ST_DONE;
			last_q    <= 1'b0;
			element_q <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.op == plst_pkg::OP_INS) held_q <= held_q + CW'(1);
						if (cmd.op == plst_pkg::OP_DEL) held_q <= held_q - CW'(1);
						rd_cnt_q <= '0;
						if (go_read) begin
							state_q <= S_READ;
						end else begin
							valid_q   <= 1'b1;
							element_q <= '0;
							status_q  <= st_d;
							last_q    <= 1'b1;
						end
					end
				end
				S_READ: begin
					valid_q   <= 1'b1;
					element_q <= cell_data[0];
					status_q  <= plst_pkg::ST_DONE;
					rd_cnt_q  <= rd_cnt_q + CW'(1);
					if (rd_cnt_q == held_q - CW'(1)) begin
						last_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						last_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy    = (state_q == S_READ);
	assign valid   = valid_q;
	assign element = element_q;
	assign status  = status_q;
	assign count   = 6'(held_q);
	assign last    = last_q;

`ifndef SYNTHESIS
	// count never passes the chain depth
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("held count above capacity");

	// any action other than read-out gives one final beat next cycle
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action != plst_pkg::ACT_READ_ALL |=> valid && last)
		else $error("missing single result beat");

	// a non-final beat only comes from a read-out still in progress
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy && status == plst_pkg::ST_DONE)
		else $error("non-final beat outside read-out");

	// error statuses always close the item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != plst_pkg::ST_DONE |-> last)
		else $error("error status on non-final beat");
`endif

endmodule
